[rtl/core/kpc_pkg.sv]
// Package for the key press classifier: sizes, register indexes and event codes.
// No dependencies; the classifier top level imports it.
package kpc_pkg;

  // Number of key inputs taken into account, and the tick counter width
  localparam int KEY_COUNT   = 4;
  localparam int COUNT_WIDTH = 16;

  // Fixed field widths
  localparam int KEYS_W  = 4;
  localparam int KIND_W  = 3;
  localparam int REG_W   = 16;
  localparam int INDEX_W = 2;

  // Compare width: room for the counter or a register, plus the carry of a sum
  localparam int CMP_W = ((COUNT_WIDTH > REG_W) ? COUNT_WIDTH : REG_W) + 1;

  // Keys above KEY_COUNT are ignored
  localparam logic [KEYS_W-1:0] KEY_MASK = KEYS_W'((64'd1 << KEY_COUNT) - 64'd1);

  // Counter ceiling
  localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;

  // Configuration register indexes
  localparam logic [INDEX_W-1:0] REG_DEBOUNCE = 2'd0;
  localparam logic [INDEX_W-1:0] REG_LONG     = 2'd1;
  localparam logic [INDEX_W-1:0] REG_REPEAT   = 2'd2;

  // Register reset values
  localparam logic [REG_W-1:0] DEBOUNCE_RST = 16'd3;
  localparam logic [REG_W-1:0] LONG_RST     = 16'd100;
  localparam logic [REG_W-1:0] REPEAT_RST   = 16'd20;

  // Event codes
  localparam logic [KIND_W-1:0] EV_PRESS    = 3'd0;
  localparam logic [KIND_W-1:0] EV_LONG     = 3'd1;
  localparam logic [KIND_W-1:0] EV_REPEAT   = 3'd2;
  localparam logic [KIND_W-1:0] EV_SHORT_UP = 3'd3;
  localparam logic [KIND_W-1:0] EV_LONG_UP  = 3'd4;

endpackage

[rtl/core/key_press_classifier.sv]
// Key press classifier: debounce, long press, hold repeat and release events.
// Depends on kpc_pkg for sizes, register indexes and event codes.
//
//  channel | ports                        | beat contents
//  --------+------------------------------+-------------------------------------------
//  in      | in_tvalid/in_tready/in_tdata | one scan tick: raw_keys
//  out     | out_tvalid/out_tready/out_tdata | one event: key_pattern, event_kind
//  cfg     | cfg_valid/cfg_ready          | register write: cfg_index, cfg_data
//
// One tick per cycle sustained while the output is not stalled. A tick is taken into the
// input register, then classified combinationally against the held pattern and counter,
// and its event, if any, lands in the output register when the input register advances.
// rst_n is synchronous; it restores the register defaults and clears the state.
// A stalled event holds the output register; the input register still drains
// into it once it frees, and an empty input register always takes a new tick.
module key_press_classifier
  import kpc_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  // in_tdata: [3:0] raw_keys, [7:4] zero
  input  logic               in_tvalid,
  output logic               in_tready,
  input  logic [7:0]         in_tdata,
  // out_tdata: [3:0] key_pattern, [6:4] event_kind, [7] zero
  output logic               out_tvalid,
  input  logic               out_tready,
  output logic [7:0]         out_tdata,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [INDEX_W-1:0] cfg_index,
  input  logic [REG_W-1:0]   cfg_data
);

  // Configuration registers
  logic [REG_W-1:0] debounce_r, long_r, repeat_r;

  // Input register
  logic              s1_valid_r;
  logic [KEYS_W-1:0] s1_keys_r;

  // Classifier state
  logic [KEYS_W-1:0]      held_r, held_nxt;
  logic [COUNT_WIDTH-1:0] count_r, count_nxt;

  // Output register
  logic              out_valid_r;
  logic [KEYS_W-1:0] out_pat_r;
  logic [KIND_W-1:0] out_kind_r;

  logic              s1_adv, s1_fire;
  logic [KEYS_W-1:0] keys;
  logic              ev_valid;
  logic [KIND_W-1:0] ev_kind;
  logic [COUNT_WIDTH-1:0] cnt_inc;
  logic [CMP_W-1:0]  cnt_ext, inc_ext, deb_ext, long_ext, rep_point;

  assign cfg_ready = 1'b1;

  // Take register writes; indexes beyond the list are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      debounce_r <= DEBOUNCE_RST;
      long_r     <= LONG_RST;
      repeat_r   <= REPEAT_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_DEBOUNCE: debounce_r <= cfg_data;
        REG_LONG:     long_r     <= cfg_data;
        REG_REPEAT:   repeat_r   <= cfg_data;
        default: ;
      endcase
    end
  end

  // Advance the input stage whenever the output register is free or draining
  assign s1_adv    = !out_valid_r || out_tready;
  assign s1_fire   = s1_valid_r && s1_adv;
  assign in_tready = !s1_valid_r || s1_adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      s1_keys_r <= in_tdata[KEYS_W-1:0];
    end
  end

  // Classify the tick against the held pattern
  assign keys      = s1_keys_r & KEY_MASK;
  assign cnt_inc   = count_r + COUNT_WIDTH'(1);
  assign cnt_ext   = CMP_W'(count_r);
  assign inc_ext   = CMP_W'(cnt_inc);
  assign deb_ext   = CMP_W'(debounce_r);
  assign long_ext  = CMP_W'(long_r);
  assign rep_point = CMP_W'(long_r) + CMP_W'(repeat_r);

  always_comb begin
    held_nxt  = held_r;
    count_nxt = count_r;
    ev_valid  = 1'b0;
    ev_kind   = EV_PRESS;
    if (keys == '0) begin
      // Release: report by how far the count got, then forget the pattern
      if (held_r != '0) begin
        if (cnt_ext >= long_ext) begin
          ev_valid = 1'b1;
          ev_kind  = EV_LONG_UP;
        end else if (cnt_ext >= deb_ext) begin
          ev_valid = 1'b1;
          ev_kind  = EV_SHORT_UP;
        end
      end
      held_nxt  = '0;
      count_nxt = '0;
    end else if (keys != held_r) begin
      held_nxt  = keys;
      count_nxt = '0;
    end else if (count_r != COUNT_MAX) begin
      // Steady pattern: count up and check thresholds in priority order
      count_nxt = cnt_inc;
      if (inc_ext == deb_ext) begin
        ev_valid = 1'b1;
        ev_kind  = EV_PRESS;
      end else if (inc_ext == long_ext) begin
        ev_valid = 1'b1;
        ev_kind  = EV_LONG;
      end else if (inc_ext == rep_point) begin
        ev_valid  = 1'b1;
        ev_kind   = EV_REPEAT;
        count_nxt = COUNT_WIDTH'(long_r);
      end
    end
  end

  // Update state on each classified tick
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_r  <= '0;
      count_r <= '0;
    end else if (s1_fire) begin
      held_r  <= held_nxt;
      count_r <= count_nxt;
    end
  end

  // Load the output register; hold it while stalled
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv) begin
      out_valid_r <= s1_fire && ev_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire && ev_valid) begin
      out_pat_r  <= held_r;
      out_kind_r <= ev_kind;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {1'b0, out_kind_r, out_pat_r};

`ifndef NO_ASSERTIONS
  // An empty held pattern always comes with a cleared counter
  a_idle_count: assert property (@(posedge clk) disable iff (!rst_n)
    held_r == '0 |-> count_r == '0)
    else $error("counter nonzero with no held pattern");

  // Every event names a held pattern
  a_event_pattern: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> out_pat_r != '0)
    else $error("event with empty key pattern");

  // A released tick always clears the held pattern
  a_release_clears: assert property (@(posedge clk) disable iff (!rst_n)
    s1_fire && keys == '0 |=> held_r == '0)
    else $error("release did not clear held pattern");

  // A stalled event is never overwritten by the input stage
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_tready |=> out_valid_r && $stable(out_pat_r) && $stable(out_kind_r))
    else $error("stalled event overwritten");

  // Event codes stay within the defined set
  a_kind_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> out_kind_r <= EV_LONG_UP)
    else $error("undefined event code");
`endif

endmodule
